>>> rtl/core/imu_fd_pkg.sv
// ----------------------------------------------------------------------------
// imu_fd_pkg
// Constants and result type shared by the IMU frame deframer modules.
// ----------------------------------------------------------------------------
package imu_fd_pkg;

    localparam int FRAME_LEN = 34;
    localparam int FILL_W    = $clog2(FRAME_LEN + 1);

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;

    localparam logic EVT_FRAME = 1'b0;
    localparam logic EVT_CSUM  = 1'b1;

    typedef struct packed {
        logic               event_res;
        logic [7:0]         msg_count;
        logic signed [31:0] gyro_x;
        logic signed [31:0] gyro_y;
        logic signed [31:0] gyro_z;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [15:0] gyro_temperature;
        logic signed [15:0] accel_temperature;
        logic [7:0]         spare_byte;
    } t_result;

endpackage

>>> rtl/core/imu_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// imu_frame_deframer_top
// Finds 34-byte IMU frames (0xAA 0x55 header, additive checksum) in a byte
// stream and reports the decoded payload or a checksum error.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+------------------------
//   input   | in        | i_in_valid / o_in_stall    | i_rx_byte
//   output  | out       | o_out_valid / i_out_stall  | o_event_res .. o_spare_byte
//
// One byte is taken per cycle while o_in_stall is low; the result for the byte
// that completes the window is registered in the result register or the skid stage.
// Synchronous reset empties the window; no clearing pass is needed.
// A skid stage lets input continue for one result while output is stalled;
// o_in_stall rises only when both output stages are occupied.
// ----------------------------------------------------------------------------
module imu_frame_deframer_top
    import imu_fd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_event_res,
    output logic [7:0]         o_msg_count,
    output logic signed [31:0] o_gyro_x,
    output logic signed [31:0] o_gyro_y,
    output logic signed [31:0] o_gyro_z,
    output logic signed [31:0] o_accel_x,
    output logic signed [31:0] o_accel_y,
    output logic signed [31:0] o_accel_z,
    output logic signed [15:0] o_gyro_temperature,
    output logic signed [15:0] o_accel_temperature,
    output logic [7:0]         o_spare_byte
);

    logic    in_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    buf_full;

    assign o_in_stall = buf_full;
    assign in_accept  = i_in_valid && !buf_full;

    imu_fd_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    imu_fd_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (out_res),
        .o_full      (buf_full)
    );

    assign o_event_res         = out_res.event_res;
    assign o_msg_count         = out_res.msg_count;
    assign o_gyro_x            = out_res.gyro_x;
    assign o_gyro_y            = out_res.gyro_y;
    assign o_gyro_z            = out_res.gyro_z;
    assign o_accel_x           = out_res.accel_x;
    assign o_accel_y           = out_res.accel_y;
    assign o_accel_z           = out_res.accel_z;
    assign o_gyro_temperature  = out_res.gyro_temperature;
    assign o_accel_temperature = out_res.accel_temperature;
    assign o_spare_byte        = out_res.spare_byte;

    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("skid stage filled while output was free");

    a_csum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.event_res == EVT_CSUM) |->
            (res.msg_count == 8'd0 && res.gyro_x == 32'sd0 && res.spare_byte == 8'd0))
        else $error("checksum error result carries payload");

    a_res_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> in_accept)
        else $error("result produced without an accepted byte");

endmodule

>>> rtl/core/imu_fd_window.sv
// ----------------------------------------------------------------------------
// imu_fd_window
// Sliding byte window with running sum; detects header and checks the sum.
// ----------------------------------------------------------------------------
module imu_fd_window
    import imu_fd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [7:0]        r_win [FRAME_LEN];
    logic [7:0]        n_win [FRAME_LEN];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [7:0]        r_sum;
    logic [7:0]        n_sum;
    logic [7:0]        head_sum;
    logic              full_now;
    logic              was_full;
    logic              hdr_ok;
    logic              sum_ok;

    always_comb begin
        for (int k = 0; k < FRAME_LEN - 1; k++) begin
            n_win[k] = r_win[k + 1];
        end
        n_win[FRAME_LEN-1] = i_rx_byte;
    end

    assign was_full = (r_fill == FILL_W'(FRAME_LEN));
    assign head_sum = was_full ? (r_sum - r_win[0]) : r_sum;
    assign n_sum    = head_sum + i_rx_byte;
    assign n_fill   = was_full ? FILL_W'(FRAME_LEN) : (r_fill + FILL_W'(1));
    assign full_now = (n_fill == FILL_W'(FRAME_LEN));
    assign hdr_ok   = (n_win[0] == HDR_FIRST) && (n_win[1] == HDR_SECOND);
    assign sum_ok   = (head_sum == i_rx_byte);

    assign o_res_valid = i_push && full_now && hdr_ok;

    always_comb begin
        o_res = '0;
        if (sum_ok) begin
            o_res.event_res         = EVT_FRAME;
            o_res.msg_count         = n_win[3];
            o_res.gyro_x            = {n_win[7], n_win[6], n_win[5], n_win[4]};
            o_res.gyro_y            = {n_win[11], n_win[10], n_win[9], n_win[8]};
            o_res.gyro_z            = {n_win[15], n_win[14], n_win[13], n_win[12]};
            o_res.accel_x           = {n_win[19], n_win[18], n_win[17], n_win[16]};
            o_res.accel_y           = {n_win[23], n_win[22], n_win[21], n_win[20]};
            o_res.accel_z           = {n_win[27], n_win[26], n_win[25], n_win[24]};
            o_res.gyro_temperature  = {n_win[29], n_win[28]};
            o_res.accel_temperature = {n_win[31], n_win[30]};
            o_res.spare_byte        = n_win[32];
        end else begin
            o_res.event_res = EVT_CSUM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int k = 0; k < FRAME_LEN; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_push) begin
            // drop the whole frame once it decodes cleanly
            if (full_now && hdr_ok && sum_ok) begin
                r_fill <= '0;
                r_sum  <= '0;
            end else begin
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
        end
    end

endmodule

>>> rtl/core/imu_fd_outbuf.sv
// ----------------------------------------------------------------------------
// imu_fd_outbuf
// Result register with one skid stage for the output channel.
// ----------------------------------------------------------------------------
module imu_fd_outbuf
    import imu_fd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_res,
    output logic    o_full
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_full      = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

>>> tb/sv/imu_fd_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// imu_fd_scoreboard_pkg
// Predicts deframer results from the accepted byte stream with a private
// 34-byte sliding window and running sum, and checks each output word
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
package imu_fd_scoreboard_pkg;
    import imu_fd_pkg::*;

    class frame_scoreboard;
        logic [7:0]  window [FRAME_LEN];
        int unsigned held;
        logic [7:0]  running_sum;
        t_result     frame_q [$];
        int unsigned predicted;
        int unsigned errors;

        function new();
            empty_window();
            predicted = 0;
            errors    = 0;
        endfunction

        function void empty_window();
            foreach (window[k]) window[k] = 8'h00;
            held        = 0;
            running_sum = 8'h00;
        endfunction

        function logic [31:0] le32(input int unsigned pos);
            return {window[pos + 3], window[pos + 2], window[pos + 1], window[pos]};
        endfunction

        function void note_byte(input logic [7:0] rx);
            t_result    r;
            logic [7:0] head_sum;
            int         k;
            if (held >= FRAME_LEN) begin
                running_sum = running_sum - window[0];
                for (k = 0; k < FRAME_LEN - 1; k++) window[k] = window[k + 1];
                held = FRAME_LEN - 1;
            end
            window[held] = rx;
            held++;
            running_sum = running_sum + rx;
            if (held < FRAME_LEN) return;
            if (window[0] != HDR_FIRST || window[1] != HDR_SECOND) return;
            head_sum = running_sum - window[FRAME_LEN - 1];
            r = '0;
            if (head_sum != window[FRAME_LEN - 1]) begin
                r.event_res = EVT_CSUM;
            end else begin
                r.event_res         = EVT_FRAME;
                r.msg_count         = window[3];
                r.gyro_x            = le32(4);
                r.gyro_y            = le32(8);
                r.gyro_z            = le32(12);
                r.accel_x           = le32(16);
                r.accel_y           = le32(20);
                r.accel_z           = le32(24);
                r.gyro_temperature  = {window[29], window[28]};
                r.accel_temperature = {window[31], window[30]};
                r.spare_byte        = window[32];
                empty_window();
            end
            frame_q.push_back(r);
            predicted++;
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got, input logic [63:0] stamp);
            if (got !== want) begin
                $display("%0d ns: %s mismatch, expected %h actual %h",
                         stamp, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input t_result got, input logic [63:0] stamp);
            t_result want;
            if (frame_q.size() == 0) begin
                $display("%0d ns: unexpected result, expected none actual %h", stamp, got);
                errors++;
                return;
            end
            want = frame_q.pop_front();
            compare_field("event_res", want.event_res, got.event_res, stamp);
            compare_field("msg_count", want.msg_count, got.msg_count, stamp);
            compare_field("gyro_x", want.gyro_x, got.gyro_x, stamp);
            compare_field("gyro_y", want.gyro_y, got.gyro_y, stamp);
            compare_field("gyro_z", want.gyro_z, got.gyro_z, stamp);
            compare_field("accel_x", want.accel_x, got.accel_x, stamp);
            compare_field("accel_y", want.accel_y, got.accel_y, stamp);
            compare_field("accel_z", want.accel_z, got.accel_z, stamp);
            compare_field("gyro_temperature", want.gyro_temperature,
                          got.gyro_temperature, stamp);
            compare_field("accel_temperature", want.accel_temperature,
                          got.accel_temperature, stamp);
            compare_field("spare_byte", want.spare_byte, got.spare_byte, stamp);
        endfunction
    endclass

endpackage

>>> tb/sv/tb_imu_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// tb_imu_frame_deframer_top
// Feeds the deframer a byte stream of directed frames (payload extremes,
// bad checksum, leading noise) followed by random frames, truncated frames
// and noise, under random input gaps and output stalls and in a final phase
// without either, and checks every output word against a scoreboard prediction.
// ----------------------------------------------------------------------------
module tb_imu_frame_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imu_fd_pkg::*;
    import imu_fd_scoreboard_pkg::*;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [7:0]         i_rx_byte   = 8'h00;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_event_res;
    logic [7:0]         o_msg_count;
    logic signed [31:0] o_gyro_x;
    logic signed [31:0] o_gyro_y;
    logic signed [31:0] o_gyro_z;
    logic signed [31:0] o_accel_x;
    logic signed [31:0] o_accel_y;
    logic signed [31:0] o_accel_z;
    logic signed [15:0] o_gyro_temperature;
    logic signed [15:0] o_accel_temperature;
    logic [7:0]         o_spare_byte;

    frame_scoreboard sb;
    logic [7:0]      frame_buf [FRAME_LEN];
    int unsigned     in_idle_pct   = 29;
    int unsigned     out_stall_pct = 48;
    int unsigned     sent_bytes    = 0;

    imu_frame_deframer_top uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_event_res         (o_event_res),
        .o_msg_count         (o_msg_count),
        .o_gyro_x            (o_gyro_x),
        .o_gyro_y            (o_gyro_y),
        .o_gyro_z            (o_gyro_z),
        .o_accel_x           (o_accel_x),
        .o_accel_y           (o_accel_y),
        .o_accel_z           (o_accel_z),
        .o_gyro_temperature  (o_gyro_temperature),
        .o_accel_temperature (o_accel_temperature),
        .o_spare_byte        (o_spare_byte)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_result({o_event_res, o_msg_count, o_gyro_x, o_gyro_y, o_gyro_z,
                             o_accel_x, o_accel_y, o_accel_z, o_gyro_temperature,
                             o_accel_temperature, o_spare_byte}, $time);
        end
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            4: return HDR_FIRST;
            5: return HDR_SECOND;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void fill_payload_random();
        int k;
        for (k = 3; k < FRAME_LEN - 1; k++) frame_buf[k] = pick_byte();
    endfunction

    function automatic void fill_payload_pattern(input logic [7:0] lo, input logic [7:0] hi,
                                                 input logic [7:0] tag);
        int k;
        frame_buf[3] = tag;
        for (k = 0; k < 6; k++) begin
            frame_buf[4 + 4 * k] = lo;
            frame_buf[5 + 4 * k] = lo;
            frame_buf[6 + 4 * k] = lo;
            frame_buf[7 + 4 * k] = hi;
        end
        frame_buf[28] = lo;
        frame_buf[29] = hi;
        frame_buf[30] = lo;
        frame_buf[31] = hi;
        frame_buf[32] = tag;
    endfunction

    function automatic void seal_frame(input bit bad_sum);
        logic [7:0] s;
        int         k;
        frame_buf[0] = HDR_FIRST;
        frame_buf[1] = HDR_SECOND;
        frame_buf[2] = 8'($urandom_range(255));
        s = 8'h00;
        for (k = 0; k < FRAME_LEN - 1; k++) s = s + frame_buf[k];
        if (bad_sum) s = s + 8'($urandom_range(255, 1));
        frame_buf[FRAME_LEN - 1] = s;
    endfunction

    task automatic send_byte(input logic [7:0] rx);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= rx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_byte(rx);
        sent_bytes++;
    endtask

    task automatic send_frame(input int unsigned len);
        int k;
        for (k = 0; k < len; k++) send_byte(frame_buf[k]);
    endtask

    task automatic run_phase(input int unsigned in_pct, input int unsigned out_pct,
                             input int unsigned min_bytes, input int unsigned min_frames);
        int unsigned bytes0;
        int unsigned frames0;
        int unsigned pick;
        bytes0        = sent_bytes;
        frames0       = sb.predicted;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        while (sent_bytes - bytes0 < min_bytes || sb.predicted - frames0 < min_frames) begin
            pick = $urandom_range(99);
            fill_payload_random();
            if (pick < 70) begin
                seal_frame(pick < 12);
                send_frame(FRAME_LEN);
            end else if (pick < 80) begin
                seal_frame(1'b0);
                send_frame($urandom_range(FRAME_LEN - 1, 2));
            end else begin
                repeat ($urandom_range(8, 1)) send_byte(pick_byte());
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(HDR_SECOND);
        send_byte(HDR_FIRST);
        send_byte(8'h00);
        send_byte(8'hFF);
        fill_payload_pattern(8'hFF, 8'h7F, 8'hFF);
        seal_frame(1'b0);
        send_frame(FRAME_LEN);
        fill_payload_pattern(8'h00, 8'h80, 8'h00);
        seal_frame(1'b0);
        send_frame(FRAME_LEN);
        fill_payload_pattern(8'h55, 8'hAA, 8'h01);
        seal_frame(1'b1);
        send_frame(FRAME_LEN);
        fill_payload_random();
        frame_buf[3] = HDR_FIRST;
        frame_buf[4] = HDR_SECOND;
        seal_frame(1'b0);
        send_frame(FRAME_LEN);

        run_phase(29, 48, 260, 6);
        run_phase(48, 29, 260, 6);
        run_phase(0, 0, 260, 6);

        i_in_valid <= 1'b0;
        while (sb.frame_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/core/imu_fd_pkg.sv
rtl/core/imu_fd_window.sv
rtl/core/imu_fd_outbuf.sv
rtl/core/imu_frame_deframer_top.sv
tb/sv/imu_fd_scoreboard_pkg.sv
tb/sv/tb_imu_frame_deframer_top.sv
